// ===== design/bba_pkg.sv =====
package bba_pkg;

	localparam int MAP_W = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	typedef enum logic [2:0] {
		REQ_CLEAR   = 3'd0,
		REQ_CONTIG  = 3'd1,
		REQ_CLAIM   = 3'd2,
		REQ_MEMBERS = 3'd3,
		REQ_LINKED  = 3'd4,
		REQ_MARK    = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CONFLICT = 2'd1,
		ST_PAST     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_RUN,
		SCAN_FIN
	} scan_state_t;

	// map update request from the sequencer; idx is also the read address
	typedef struct packed {
		logic             clear;
		logic             set_en;
		logic [IDX_W-1:0] idx;
		logic             or_en;
		logic [MAP_W-1:0] or_mask;
	} map_cmd_t;

	typedef struct packed {
		status_t          status;
		logic [MAP_W-1:0] taken_mask;
		logic [CNT_W-1:0] taken_count;
		logic [CNT_W-1:0] conflict_count;
	} result_t;

endpackage

// ===== design/bba_map.sv =====
module bba_map #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::map_cmd_t cmd,
	output logic              rd_bit
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	logic [NUM_BLOCKS-1:0] map_q;
	logic [AW-1:0]         idx;

	assign idx    = cmd.idx[AW-1:0];
	assign rd_bit = map_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (cmd.clear) begin
			map_q <= '0;
		end else begin
			if (cmd.set_en)
				map_q[idx] <= 1'b1;
			if (cmd.or_en)
				map_q <= map_q | cmd.or_mask[NUM_BLOCKS-1:0];
		end
	end

endmodule

// ===== design/bba_scan.sv =====
module bba_scan #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [2:0]                req_type,
	input  logic [5:0]                start_block,
	input  logic [6:0]                block_count,
	input  logic [5:0]                block_number,
	input  logic [63:0]               member_mask,
	input  logic                      map_bit,
	input  logic                      res_take,
	output logic                      busy,
	output logic                      res_valid,
	output bba_pkg::result_t          res,
	output bba_pkg::map_cmd_t         cmd
);

	localparam logic [bba_pkg::CNT_W-1:0] NB_C = bba_pkg::CNT_W'(NUM_BLOCKS);
	localparam logic [bba_pkg::MAP_W-1:0] VMASK = (NUM_BLOCKS >= bba_pkg::MAP_W) ?
		{bba_pkg::MAP_W{1'b1}} :
		((bba_pkg::MAP_W'(1) << NUM_BLOCKS) - bba_pkg::MAP_W'(1));

	bba_pkg::scan_state_t state_q, state_d;
	bba_pkg::req_t        req_q;
	bba_pkg::status_t     st_q, st_d;

	logic [bba_pkg::CNT_W-1:0] cur_q, cur_d;
	logic [bba_pkg::CNT_W-1:0] rem_q, rem_d;
	logic [bba_pkg::CNT_W-1:0] tk_q, tk_d;
	logic [bba_pkg::CNT_W-1:0] cf_q, cf_d;
	logic [bba_pkg::MAP_W-1:0] mask_q;
	logic [bba_pkg::MAP_W-1:0] sh_q, sh_d;
	logic [bba_pkg::MAP_W-1:0] taken_q, taken_d;
	logic                      oor_q;
	logic                      fin;
	logic                      past;
	logic                      rem_zero;
	logic                      single;

	assign past     = (cur_q >= NB_C);
	assign rem_zero = (rem_q == '0);
	assign single   = (req_type == bba_pkg::REQ_CLAIM) || (req_type == bba_pkg::REQ_MARK);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bba_pkg::SCAN_IDLE: if (start)    state_d = bba_pkg::SCAN_RUN;
			bba_pkg::SCAN_RUN:  if (fin)      state_d = bba_pkg::SCAN_FIN;
			bba_pkg::SCAN_FIN:  if (res_take) state_d = bba_pkg::SCAN_IDLE;
			default:                          state_d = bba_pkg::SCAN_IDLE;
		endcase
	end

	// one step of the current request
	always_comb begin
		fin     = 1'b0;
		cmd     = '0;
		cmd.idx = cur_q[bba_pkg::IDX_W-1:0];
		cur_d   = cur_q;
		rem_d   = rem_q;
		tk_d    = tk_q;
		cf_d    = cf_q;
		st_d    = st_q;
		sh_d    = sh_q;
		taken_d = taken_q;
		if (state_q == bba_pkg::SCAN_RUN) begin
			case (req_q)
				bba_pkg::REQ_CLEAR: begin
					cmd.clear = 1'b1;
					fin       = 1'b1;
				end
				bba_pkg::REQ_CLAIM, bba_pkg::REQ_MARK: begin
					fin = 1'b1;
					if (past) begin
						st_d = bba_pkg::ST_PAST;
					end else if (map_bit) begin
						cf_d = bba_pkg::CNT_W'(1);
						st_d = (req_q == bba_pkg::REQ_CLAIM) ? bba_pkg::ST_CONFLICT
						                                      : bba_pkg::ST_OK;
					end else begin
						cmd.set_en = 1'b1;
						taken_d[cur_q[bba_pkg::IDX_W-1:0]] = 1'b1;
						tk_d = bba_pkg::CNT_W'(1);
					end
				end
				bba_pkg::REQ_CONTIG, bba_pkg::REQ_LINKED: begin
					if (rem_zero) begin
						fin = 1'b1;
						if (req_q == bba_pkg::REQ_CONTIG && cf_q != '0)
							st_d = bba_pkg::ST_CONFLICT;
					end else if (past) begin
						fin  = 1'b1;
						st_d = bba_pkg::ST_PAST;
					end else begin
						cur_d = cur_q + bba_pkg::CNT_W'(1);
						if (map_bit) begin
							cf_d = cf_q + bba_pkg::CNT_W'(1);
							if (req_q == bba_pkg::REQ_CONTIG)
								rem_d = rem_q - bba_pkg::CNT_W'(1);
						end else begin
							cmd.set_en = 1'b1;
							taken_d[cur_q[bba_pkg::IDX_W-1:0]] = 1'b1;
							tk_d  = tk_q + bba_pkg::CNT_W'(1);
							rem_d = rem_q - bba_pkg::CNT_W'(1);
						end
					end
				end
				bba_pkg::REQ_MEMBERS: begin
					if (oor_q) begin
						fin  = 1'b1;
						st_d = bba_pkg::ST_PAST;
					end else if (past) begin
						// all members checked: commit all or nothing
						fin = 1'b1;
						if (cf_q != '0) begin
							st_d = bba_pkg::ST_CONFLICT;
							tk_d = '0;
						end else begin
							cmd.or_en   = 1'b1;
							cmd.or_mask = mask_q;
							taken_d     = mask_q;
						end
					end else begin
						cf_d  = cf_q + bba_pkg::CNT_W'(sh_q[0] & map_bit);
						tk_d  = tk_q + bba_pkg::CNT_W'(sh_q[0]);
						sh_d  = sh_q >> 1;
						cur_d = cur_q + bba_pkg::CNT_W'(1);
					end
				end
				default: begin
					fin  = 1'b1;
					st_d = bba_pkg::ST_CONFLICT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bba_pkg::SCAN_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == bba_pkg::SCAN_IDLE && start) begin
			req_q   <= bba_pkg::req_t'(req_type);
			if (single)
				cur_q <= {1'b0, block_number};
			else if (req_type == bba_pkg::REQ_MEMBERS)
				cur_q <= '0;
			else
				cur_q <= {1'b0, start_block};
			rem_q   <= block_count;
			mask_q  <= member_mask;
			sh_q    <= member_mask;
			oor_q   <= |(member_mask & ~VMASK);
			taken_q <= '0;
			tk_q    <= '0;
			cf_q    <= '0;
			st_q    <= bba_pkg::ST_OK;
		end else begin
			cur_q   <= cur_d;
			rem_q   <= rem_d;
			sh_q    <= sh_d;
			taken_q <= taken_d;
			tk_q    <= tk_d;
			cf_q    <= cf_d;
			st_q    <= st_d;
		end
	end

	assign busy      = (state_q != bba_pkg::SCAN_IDLE);
	assign res_valid = (state_q == bba_pkg::SCAN_FIN);

	always_comb begin
		res.status         = st_q;
		res.taken_mask     = taken_q;
		res.taken_count    = tk_q;
		res.conflict_count = cf_q;
	end

endmodule

// ===== design/block_bitmap_allocator_core.sv =====
// Block bitmap allocator: one used/free bit per disk block, one request word
// at a time. Clear, claim-index and mark-used requests end without walking
// the map. Contiguous and linked requests walk the map one block per cycle
// from start_block, visiting at most NUM_BLOCKS blocks. An index-member
// request shifts member_mask past the map one bit per cycle and always walks
// the whole map (it ends at once when a member lies past the last block).
// A new request is taken once the previous result has moved into the output
// register, which may still be waiting on rsp_stall.
module block_bitmap_allocator_core #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [5:0]  start_block,
	input  logic [6:0]  block_count,
	input  logic [5:0]  block_number,
	input  logic [63:0] member_mask,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [63:0] taken_mask,
	output logic [6:0]  taken_count,
	output logic [6:0]  conflict_count
);

	bba_pkg::map_cmd_t cmd;
	bba_pkg::result_t  res;
	logic              map_bit;
	logic              busy;
	logic              res_valid;
	logic              res_take;
	logic              out_free;
	logic              rsp_valid_q;
	bba_pkg::result_t  rsp_q;

	assign req_stall = busy;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign res_take  = res_valid && out_free;

	bba_map #(.NUM_BLOCKS(NUM_BLOCKS)) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_bit (map_bit)
	);

	bba_scan #(.NUM_BLOCKS(NUM_BLOCKS)) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (req_valid && !req_stall),
		.req_type     (req_type),
		.start_block  (start_block),
		.block_count  (block_count),
		.block_number (block_number),
		.member_mask  (member_mask),
		.map_bit      (map_bit),
		.res_take     (res_take),
		.busy         (busy),
		.res_valid    (res_valid),
		.res          (res),
		.cmd          (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (out_free)
			rsp_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_take)
			rsp_q <= res;
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_q.status;
	assign taken_mask     = rsp_q.taken_mask;
	assign taken_count    = rsp_q.taken_count;
	assign conflict_count = rsp_q.conflict_count;

endmodule

// ===== design/bba_checker.sv =====
module bba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  status,
	input logic [63:0] taken_mask,
	input logic [6:0]  taken_count,
	input logic [6:0]  conflict_count
);

	// a word just accepted keeps the sequencer busy next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted but not busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(taken_mask) && $stable(status))
		else $error("stalled response changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> taken_count <= 7'd64 && conflict_count <= 7'd64)
		else $error("count out of range");

	a_zero_taken: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && taken_count == 7'd0 |-> taken_mask == 64'd0)
		else $error("taken mask set with zero taken count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != 2'd3)
		else $error("undefined status");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.status         (status),
	.taken_mask     (taken_mask),
	.taken_count    (taken_count),
	.conflict_count (conflict_count)
);

// ===== dv/block_bitmap_allocator_core_tb.sv =====
module block_bitmap_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BLOCKS = 64;
	localparam logic [2:0] REQ_UNUSED_A = 3'd6;
	localparam logic [2:0] REQ_UNUSED_B = 3'd7;
	localparam int RANDOM_WORDS = 1625;
	localparam int HOLD_AFTER = 450;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1200000;
	localparam int MAX_REPORTS = 10;

	class block_map_tracker;
		logic [63:0] used_map;
		bba_pkg::result_t pending_results[$];
		int mismatches;

		function new();
			used_map = '0;
			mismatches = 0;
		endfunction

		// work out the grant for one accepted request word and update the map
		function void note_request(logic [2:0] kind, logic [5:0] first, logic [6:0] want,
				logic [5:0] idx, logic [63:0] members);
			bba_pkg::result_t grant;
			logic [63:0] valid_blocks;
			int j;
			int got;
			int clashes;

			valid_blocks = (NUM_BLOCKS >= 64) ? '1 : ((64'd1 << NUM_BLOCKS) - 64'd1);
			grant.status = bba_pkg::ST_OK;
			grant.taken_mask = '0;
			clashes = 0;
			case (kind)
				bba_pkg::REQ_CLEAR: begin
					used_map = '0;
				end
				bba_pkg::REQ_CONTIG: begin
					for (j = int'(first); j < int'(first) + int'(want); j++) begin
						if (j >= NUM_BLOCKS) begin
							grant.status = bba_pkg::ST_PAST;
							break;
						end
						if (used_map[j]) begin
							clashes++;
						end else begin
							used_map[j] = 1'b1;
							grant.taken_mask[j] = 1'b1;
						end
					end
					if (grant.status != bba_pkg::ST_PAST && clashes != 0)
						grant.status = bba_pkg::ST_CONFLICT;
				end
				bba_pkg::REQ_CLAIM, bba_pkg::REQ_MARK: begin
					if (int'(idx) >= NUM_BLOCKS) begin
						grant.status = bba_pkg::ST_PAST;
					end else if (used_map[idx]) begin
						// a claim is rejected, a mark just reports the block as taken
						clashes = 1;
						if (kind == bba_pkg::REQ_CLAIM)
							grant.status = bba_pkg::ST_CONFLICT;
					end else begin
						used_map[idx] = 1'b1;
						grant.taken_mask[idx] = 1'b1;
					end
				end
				bba_pkg::REQ_MEMBERS: begin
					if ((members & ~valid_blocks) != '0) begin
						grant.status = bba_pkg::ST_PAST;
					end else if ((members & used_map) != '0) begin
						grant.status = bba_pkg::ST_CONFLICT;
						clashes = $countones(members & used_map);
					end else begin
						used_map = used_map | members;
						grant.taken_mask = members;
					end
				end
				bba_pkg::REQ_LINKED: begin
					got = 0;
					j = int'(first);
					while (got < int'(want)) begin
						if (j >= NUM_BLOCKS) begin
							grant.status = bba_pkg::ST_PAST;
							break;
						end
						if (used_map[j]) begin
							clashes++;
						end else begin
							used_map[j] = 1'b1;
							grant.taken_mask[j] = 1'b1;
							got++;
						end
						j++;
					end
				end
				default: begin
					grant.status = bba_pkg::ST_CONFLICT;
				end
			endcase
			used_map = used_map & valid_blocks;
			grant.taken_count = bba_pkg::CNT_W'($countones(grant.taken_mask));
			grant.conflict_count = bba_pkg::CNT_W'(clashes);
			pending_results.push_back(grant);
		endfunction

		function void check_grant(logic [1:0] st, logic [63:0] tmask, logic [6:0] tcount,
				logic [6:0] ccount);
			bba_pkg::result_t grant;

			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result word with nothing pending: status %0d mask %h",
						$realtime, st, tmask);
				return;
			end
			grant = pending_results.pop_front();
			if (st !== grant.status || tmask !== grant.taken_mask
					|| tcount !== grant.taken_count || ccount !== grant.conflict_count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: mismatch exp status %0d mask %h taken %0d conflicts %0d",
						$realtime, grant.status, grant.taken_mask, grant.taken_count,
						grant.conflict_count);
					$display("%0t:          got status %0d mask %h taken %0d conflicts %0d",
						$realtime, st, tmask, tcount, ccount);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [2:0] req_type;
	logic [5:0] start_block;
	logic [6:0] block_count;
	logic [5:0] block_number;
	logic [63:0] member_mask;
	logic rsp_valid;
	logic rsp_stall;
	logic [1:0] status;
	logic [63:0] taken_mask;
	logic [6:0] taken_count;
	logic [6:0] conflict_count;

	block_map_tracker tracker;
	int words_sent = 0;
	bit quiet = 1'b0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	block_bitmap_allocator_core #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.start_block(start_block),
		.block_count(block_count),
		.block_number(block_number),
		.member_mask(member_mask),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.taken_mask(taken_mask),
		.taken_count(taken_count),
		.conflict_count(conflict_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one; none at all in quiet phases
	function automatic int gap_len();
		int pick;

		pick = $urandom_range(0, 99);
		if (quiet || pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic issue_request(input logic [2:0] kind, input logic [5:0] first,
			input logic [6:0] want, input logic [5:0] idx, input logic [63:0] members);
		req_valid <= 1'b1;
		req_type <= kind;
		start_block <= first;
		block_count <= want;
		block_number <= idx;
		member_mask <= members;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		words_sent++;
		tracker.note_request(kind, first, want, idx, members);
	endtask

	task automatic sender_pause();
		int n;

		n = gap_len();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic issue_random_request();
		int pick;
		logic [2:0] kind;
		logic [6:0] want;
		logic [63:0] members;

		pick = $urandom_range(0, 99);
		if (pick < 4)
			kind = bba_pkg::REQ_CLEAR;
		else if (pick < 24)
			kind = bba_pkg::REQ_CONTIG;
		else if (pick < 38)
			kind = bba_pkg::REQ_CLAIM;
		else if (pick < 54)
			kind = bba_pkg::REQ_MEMBERS;
		else if (pick < 76)
			kind = bba_pkg::REQ_LINKED;
		else if (pick < 94)
			kind = bba_pkg::REQ_MARK;
		else if (pick < 97)
			kind = REQ_UNUSED_A;
		else
			kind = REQ_UNUSED_B;

		want = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 10))
			: 7'($urandom_range(0, 64));

		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			members = '0;
			repeat ($urandom_range(1, 3)) members[$urandom_range(0, 63)] = 1'b1;
		end else if (pick < 60) begin
			members = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		end else if (pick < 85) begin
			members = {$urandom, $urandom};
		end else if (pick < 93) begin
			members = '0;
		end else begin
			members = '1;
		end

		issue_request(kind, 6'($urandom_range(0, 63)), want, 6'($urandom_range(0, 63)),
			members);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
			tracker.check_grant(status, taken_mask, taken_count, conflict_count);
	end

	// result side: random stalls plus one long hold-off to back up the block
	initial begin
		int stall_left;
		int hold_left;

		stall_left = 0;
		hold_left = 0;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && words_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
				stall_left = gap_len();
			end
		end
	end

	initial begin
		int i;

		tracker = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_type <= bba_pkg::REQ_CLEAR;
		start_block <= '0;
		block_count <= '0;
		block_number <= '0;
		member_mask <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_request(bba_pkg::REQ_CLEAR, 6'd0, 7'd0, 6'd0, '0);
		// zero-length requests, at both ends of the map
		issue_request(bba_pkg::REQ_CONTIG, 6'd0, 7'd0, 6'd0, '0);
		issue_request(bba_pkg::REQ_LINKED, 6'd63, 7'd0, 6'd0, '0);
		issue_request(bba_pkg::REQ_CONTIG, 6'd0, 7'd8, 6'd0, '0);
		sender_pause();
		issue_request(bba_pkg::REQ_CONTIG, 6'd4, 7'd8, 6'd0, '0);
		issue_request(bba_pkg::REQ_CONTIG, 6'd60, 7'd10, 6'd0, '0);
		issue_request(bba_pkg::REQ_CLAIM, 6'd0, 7'd0, 6'd20, '0);
		issue_request(bba_pkg::REQ_CLAIM, 6'd0, 7'd0, 6'd20, '0);
		issue_request(bba_pkg::REQ_MARK, 6'd0, 7'd0, 6'd21, '0);
		issue_request(bba_pkg::REQ_MARK, 6'd0, 7'd0, 6'd21, '0);
		issue_request(bba_pkg::REQ_MEMBERS, 6'd0, 7'd0, 6'd0, 64'h0000_0001_C000_0000);
		issue_request(bba_pkg::REQ_MEMBERS, 6'd0, 7'd0, 6'd0, 64'h0000_0100_8000_0000);
		issue_request(bba_pkg::REQ_MEMBERS, 6'd0, 7'd0, 6'd0, '0);
		// linked skips used blocks, then one that runs off the end
		issue_request(bba_pkg::REQ_LINKED, 6'd0, 7'd5, 6'd0, '0);
		issue_request(bba_pkg::REQ_LINKED, 6'd50, 7'd64, 6'd0, '0);
		issue_request(REQ_UNUSED_A, 6'd63, 7'd64, 6'd63, '1);
		issue_request(REQ_UNUSED_B, 6'd0, 7'd1, 6'd1, '0);
		issue_request(bba_pkg::REQ_CLEAR, 6'd0, 7'd0, 6'd0, '0);
		issue_request(bba_pkg::REQ_CONTIG, 6'd0, 7'd64, 6'd0, '0);
		issue_request(bba_pkg::REQ_LINKED, 6'd0, 7'd1, 6'd0, '0);
		issue_request(bba_pkg::REQ_MEMBERS, 6'd0, 7'd0, 6'd0, '1);
		issue_request(bba_pkg::REQ_CLEAR, 6'd0, 7'd0, 6'd0, '0);
		issue_request(bba_pkg::REQ_MEMBERS, 6'd0, 7'd0, 6'd0, '1);
		issue_request(bba_pkg::REQ_CLEAR, 6'd0, 7'd0, 6'd0, '0);
		issue_request(bba_pkg::REQ_LINKED, 6'd63, 7'd1, 6'd0, '0);
		issue_request(bba_pkg::REQ_CLAIM, 6'd0, 7'd0, 6'd63, '0);
		issue_request(bba_pkg::REQ_MARK, 6'd0, 7'd0, 6'd0, '0);

		for (i = 0; i < RANDOM_WORDS; i++) begin
			quiet = (words_sent >= 420 && words_sent < 700)
				|| (words_sent >= 1300 && words_sent < 1400);
			issue_random_request();
			sender_pause();
		end
		req_valid <= 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/bba_pkg.sv
design/bba_map.sv
design/bba_scan.sv
design/block_bitmap_allocator_core.sv
design/bba_checker.sv
dv/block_bitmap_allocator_core_tb.sv
